// File: rtl/separable_window_min_max_filter_unit_defines.svh
// Assertion macros for the separable window min/max filter.
`ifndef SEPARABLE_WINDOW_MIN_MAX_FILTER_UNIT_DEFINES_SVH
`define SEPARABLE_WINDOW_MIN_MAX_FILTER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SWMM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window filter: same-cycle check failed");
`define SWMM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("window filter: next-cycle check failed");
`else
`define SWMM_ASSERT_IMP(label, ante, cons)
`define SWMM_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: rtl/swmm_pkg.sv
// Shared constants, types and helpers of the window min/max filter.
`default_nettype none
package swmm_pkg;

    localparam int WINDOW     = 5;
    localparam int LINES      = WINDOW - 1;
    localparam int HALF       = (WINDOW - 1) / 2;
    localparam int LAG        = LINES - HALF;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 12;
    localparam int POS_W  = 11;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int EW_W   = COL_W + 1;
    localparam int EH_W   = ROW_W + 1;
    localparam int SLOT_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MODE   = 2'd2
    } reg_idx_t;

    typedef enum logic {
        MODE_MIN = 1'b0,
        MODE_MAX = 1'b1
    } mode_t;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic [EW_W-1:0] width;
        logic [EH_W-1:0] height;
        mode_t           mode;
        logic            restart;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        pixel_t           pixel;
        logic             emit;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             done;
    } stage_t;

    function automatic pixel_t pick(input mode_t m, input pixel_t a, input pixel_t b);
        if (m == MODE_MAX)
        begin
            return (a > b) ? a : b;
        end
        return (a < b) ? a : b;
    endfunction

endpackage
`default_nettype wire

// File: rtl/swmm_pix_if.sv
// Pixel input channel.
`default_nettype none
interface swmm_pix_if;
    logic            valid;
    logic            ready;
    swmm_pkg::pixel_t pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface
`default_nettype wire

// File: rtl/swmm_res_if.sv
// Filtered result channel.
`default_nettype none
interface swmm_res_if;
    logic                        valid;
    logic                        ready;
    swmm_pkg::pixel_t            filtered_value;
    logic [swmm_pkg::POS_W-1:0]  center_row;
    logic [swmm_pkg::POS_W-1:0]  center_column;
    logic                        frame_done;

    modport source (output valid, output filtered_value, output center_row,
                    output center_column, output frame_done, input ready);
    modport sink   (input valid, input filtered_value, input center_row,
                    input center_column, input frame_done, output ready);
endinterface
`default_nettype wire

// File: rtl/swmm_ram.sv
// Generic simple dual-port RAM, registered read, old data on a read/write collision.
`default_nettype none
module swmm_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 2048,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             re,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: rtl/swmm_cfg.sv
// APB register block: frame size and reduction mode.
`default_nettype none
module swmm_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [swmm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [swmm_pkg::DATA_W-1:0]   pwdata,
    output logic      [swmm_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output swmm_pkg::cfg_t                     cfg
);

    logic [swmm_pkg::CFG_W-1:0] width_reg;
    logic [swmm_pkg::CFG_W-1:0] height_reg;
    swmm_pkg::mode_t            mode_reg;
    swmm_pkg::reg_idx_t         idx;
    logic                       wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = swmm_pkg::reg_idx_t'(paddr[swmm_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= swmm_pkg::CFG_W'(640);
            height_reg <= swmm_pkg::CFG_W'(480);
            mode_reg   <= swmm_pkg::MODE_MIN;
        end
        else if (wr)
        begin
            case (idx)
                swmm_pkg::REG_WIDTH:  width_reg  <= pwdata[swmm_pkg::CFG_W-1:0];
                swmm_pkg::REG_HEIGHT: height_reg <= pwdata[swmm_pkg::CFG_W-1:0];
                swmm_pkg::REG_MODE:   mode_reg   <= swmm_pkg::mode_t'(pwdata[0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            swmm_pkg::REG_WIDTH:  prdata = swmm_pkg::DATA_W'(width_reg);
            swmm_pkg::REG_HEIGHT: prdata = swmm_pkg::DATA_W'(height_reg);
            swmm_pkg::REG_MODE:   prdata = {{(swmm_pkg::DATA_W-1){1'b0}}, mode_reg};
            default:              prdata = '0;
        endcase
    end

    // Sizes saturate to 1 .. maximum.
    always_comb
    begin
        if (width_reg == '0)
            cfg.width = swmm_pkg::EW_W'(1);
        else if (int'(width_reg) > swmm_pkg::MAX_WIDTH)
            cfg.width = swmm_pkg::EW_W'(swmm_pkg::MAX_WIDTH);
        else
            cfg.width = swmm_pkg::EW_W'(width_reg);

        if (height_reg == '0)
            cfg.height = swmm_pkg::EH_W'(1);
        else if (int'(height_reg) > swmm_pkg::MAX_HEIGHT)
            cfg.height = swmm_pkg::EH_W'(swmm_pkg::MAX_HEIGHT);
        else
            cfg.height = swmm_pkg::EH_W'(height_reg);

        cfg.mode    = mode_reg;
        cfg.restart = wr && ((idx == swmm_pkg::REG_WIDTH) || (idx == swmm_pkg::REG_HEIGHT));
    end

endmodule
`default_nettype wire

// File: rtl/swmm_scan.sv
// Raster position tracking, line buffers and the read stage.
`default_nettype none
module swmm_scan (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       in_valid,
    input  wire swmm_pkg::pixel_t                           in_pixel,
    output logic                                            in_ready,
    input  wire swmm_pkg::cfg_t                             cfg,
    input  wire logic                                       a_fire,
    output swmm_pkg::stage_t                                stage,
    output logic [swmm_pkg::LINES-1:0][swmm_pkg::PIX_W-1:0] col_data
);

    logic [swmm_pkg::COL_W-1:0]  col_reg, col_next;
    logic [swmm_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [swmm_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [swmm_pkg::EW_W-1:0]   col_inc;
    logic [swmm_pkg::EH_W-1:0]   row_inc;
    logic                        last_col, last_row, accept;
    swmm_pkg::stage_t            stage_reg, stage_next;

    assign in_ready = !stage_reg.valid || a_fire;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        col_inc  = {1'b0, col_reg} + swmm_pkg::EW_W'(1);
        row_inc  = {1'b0, row_reg} + swmm_pkg::EH_W'(1);
        last_col = col_inc >= cfg.width;
        last_row = row_inc >= cfg.height;

        col_next  = last_col ? '0 : col_inc[swmm_pkg::COL_W-1:0];
        row_next  = row_reg;
        slot_next = slot_reg;
        if (last_col)
        begin
            if (last_row)
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = row_inc[swmm_pkg::ROW_W-1:0];
                slot_next = (slot_reg == swmm_pkg::SLOT_W'(swmm_pkg::LINES - 1))
                            ? '0 : slot_reg + swmm_pkg::SLOT_W'(1);
            end
        end

        stage_next.valid = accept;
        stage_next.pixel = in_pixel;
        stage_next.emit  = (row_reg >= swmm_pkg::ROW_W'(swmm_pkg::LINES))
                           && (col_reg >= swmm_pkg::COL_W'(swmm_pkg::LINES));
        stage_next.row   = swmm_pkg::POS_W'(row_reg - swmm_pkg::ROW_W'(swmm_pkg::LAG));
        stage_next.col   = swmm_pkg::POS_W'(col_reg - swmm_pkg::COL_W'(swmm_pkg::LAG));
        stage_next.done  = (row_inc == cfg.height) && (col_inc == cfg.width);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (cfg.restart)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (in_ready)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

    // One buffer per stored row; the slot being overwritten still yields its old
    // row on the same read, so every buffer joins the vertical reduction.
    for (genvar k = 0; k < swmm_pkg::LINES; k++)
    begin : g_line
        swmm_ram #(
            .WIDTH (swmm_pkg::PIX_W),
            .DEPTH (swmm_pkg::MAX_WIDTH)
        ) u_line (
            .clk     (clk),
            .we      (accept && (slot_reg == swmm_pkg::SLOT_W'(k))),
            .wr_addr (col_reg),
            .wr_data (in_pixel),
            .re      (accept),
            .rd_addr (col_reg),
            .rd_data (col_data[k])
        );
    end

endmodule
`default_nettype wire

// File: rtl/swmm_reduce.sv
// Vertical and horizontal min/max reduction and the result register.
`default_nettype none
module swmm_reduce (
    input  wire logic                                             clk,
    input  wire logic                                             rst_n,
    input  wire swmm_pkg::stage_t                                 stage,
    input  wire logic [swmm_pkg::LINES-1:0][swmm_pkg::PIX_W-1:0]  col_data,
    input  wire swmm_pkg::mode_t                                  mode,
    output logic                                                  a_fire,
    output logic                                                  out_valid,
    input  wire logic                                             out_ready,
    output swmm_pkg::pixel_t                                      filtered_value,
    output logic [swmm_pkg::POS_W-1:0]                            center_row,
    output logic [swmm_pkg::POS_W-1:0]                            center_column,
    output logic                                                  frame_done
);

    logic [swmm_pkg::LINES-1:0][swmm_pkg::PIX_W-1:0] colred_reg;
    swmm_pkg::pixel_t           vert, win, filtered_reg;
    logic [swmm_pkg::POS_W-1:0] row_reg, col_reg;
    logic                       done_reg, out_valid_reg, out_free;

    assign out_free = !out_valid_reg || out_ready;
    // A stage item with no result never waits for the output side.
    assign a_fire   = stage.valid && (!stage.emit || out_free);

    always_comb
    begin
        vert = stage.pixel;
        for (int k = 0; k < swmm_pkg::LINES; k++)
        begin
            vert = swmm_pkg::pick(mode, vert, col_data[k]);
        end
        win = vert;
        for (int k = 0; k < swmm_pkg::LINES; k++)
        begin
            win = swmm_pkg::pick(mode, win, colred_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            for (int k = swmm_pkg::LINES - 1; k > 0; k--)
            begin
                colred_reg[k] <= colred_reg[k-1];
            end
            colred_reg[0] <= vert;
        end
        if (a_fire && stage.emit)
        begin
            filtered_reg <= win;
            row_reg      <= stage.row;
            col_reg      <= stage.col;
            done_reg     <= stage.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (a_fire && stage.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = filtered_reg;
    assign center_row     = row_reg;
    assign center_column  = col_reg;
    assign frame_done     = done_reg;

endmodule
`default_nettype wire

// File: rtl/separable_window_min_max_filter_unit.sv
// Each accepted pixel reads the same column of the four stored rows from four line buffers
// (one 2048 x 8 RAM per row, one read and one write per clock) and writes itself into the
// oldest; the column minimum or maximum then joins the last four column results of the row.
// The pixel at (R+2, C+2) completes the window of centre (R, C); the block sustains one
// pixel per clock unless the result output stalls, bounded by the single read and write
// port of each line buffer. Results come only for centres whose whole 5x5 window lies in
// the frame; frame_done marks the one caused by the frame's last pixel. The line buffers
// hold no reset contents and need no clearing pass. Writing image_width or image_height
// restarts the frame; registers are to be written only while the filter is idle.
`default_nettype none
`include "separable_window_min_max_filter_unit_defines.svh"
module separable_window_min_max_filter_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    swmm_pix_if.sink                           pixel_in,
    swmm_res_if.source                         result_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [swmm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [swmm_pkg::DATA_W-1:0]   pwdata,
    output logic      [swmm_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    swmm_pkg::cfg_t                                  cfg;
    swmm_pkg::stage_t                                stage;
    logic [swmm_pkg::LINES-1:0][swmm_pkg::PIX_W-1:0] col_data;
    logic                                            a_fire;

    swmm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swmm_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel_in.valid),
        .in_pixel (pixel_in.pixel_value),
        .in_ready (pixel_in.ready),
        .cfg      (cfg),
        .a_fire   (a_fire),
        .stage    (stage),
        .col_data (col_data)
    );

    swmm_reduce u_reduce (
        .clk            (clk),
        .rst_n          (rst_n),
        .stage          (stage),
        .col_data       (col_data),
        .mode           (cfg.mode),
        .a_fire         (a_fire),
        .out_valid      (result_out.valid),
        .out_ready      (result_out.ready),
        .filtered_value (result_out.filtered_value),
        .center_row     (result_out.center_row),
        .center_column  (result_out.center_column),
        .frame_done     (result_out.frame_done)
    );

    // Empty read stage must never hold off a request.
    `SWMM_ASSERT_IMP(a_ready_when_empty, !stage.valid, pixel_in.ready)
    // Every accepted pixel lands in the read stage.
    `SWMM_ASSERT_NXT(a_accept_fills_stage, pixel_in.valid && pixel_in.ready, stage.valid)
    // The frame's last result sits at the last full-window centre column.
    `SWMM_ASSERT_IMP(a_last_column, result_out.valid && result_out.frame_done, result_out.center_column == swmm_pkg::POS_W'(cfg.width - swmm_pkg::EW_W'(swmm_pkg::HALF + 1)))

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the separable 5x5 window min/max filter unit.
`timescale 1ns / 1ps
module tb_top;
    import swmm_pkg::*;

    localparam int unsigned REG_UNMAPPED   = 3;
    localparam int unsigned SETTLE_CYCLES  = 12;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int unsigned REPORT_MAX     = 10;
    localparam int unsigned EXTREME_PIXELS = 200;

    typedef enum int unsigned {
        PIX_UNIFORM,
        PIX_EXTREME,
        PIX_BAND
    } pixel_style_t;

    typedef struct packed {
        pixel_t           value;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             done;
    } window_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    swmm_pix_if pixel_bus ();
    swmm_res_if result_bus ();

    separable_window_min_max_filter_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_in   (pixel_bus),
        .result_out (result_bus),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // shadow of the filter state
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    mode_t            mode_reg;
    pixel_t           line_mem [LINES][MAX_WIDTH];
    pixel_t           column_hist [LINES];
    int unsigned      next_row;
    int unsigned      next_col;
    int unsigned      oldest_line;

    window_result_t pending_results[$];

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned pixels_sent;
    int unsigned results_checked;
    int unsigned frames_set;
    int unsigned mode_switches;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("separable_window_min_max_filter_unit regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic pixel_t reduce_pair(input pixel_t a, input pixel_t b);
        if (mode_reg == MODE_MAX)
        begin
            return (a > b) ? a : b;
        end
        return (a < b) ? a : b;
    endfunction

    task automatic apply_register(input int unsigned idx, input logic [DATA_W-1:0] value);
        begin
            if (idx == int'(REG_WIDTH))
            begin
                width_reg   = value[CFG_W-1:0];
                next_row    = 0;
                next_col    = 0;
                oldest_line = 0;
            end
            else if (idx == int'(REG_HEIGHT))
            begin
                height_reg  = value[CFG_W-1:0];
                next_row    = 0;
                next_col    = 0;
                oldest_line = 0;
            end
            else if (idx == int'(REG_MODE))
            begin
                mode_reg = mode_t'(value[0]);
            end
        end
    endtask

    // column reduction over stored rows, then row reduction over column history
    task automatic predict_pixel(input pixel_t px);
        int unsigned    w;
        int unsigned    h;
        int unsigned    c;
        int unsigned    r;
        pixel_t         column_val;
        pixel_t         window_val;
        window_result_t res;
        begin
            w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
            h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
            c = next_col;
            r = next_row;
            if (c >= MAX_WIDTH)
            begin
                c = MAX_WIDTH - 1;
            end
            if (oldest_line >= LINES)
            begin
                oldest_line = 0;
            end
            column_val = px;
            for (int k = 0; k < LINES; k++)
            begin
                column_val = reduce_pair(column_val, line_mem[k][c]);
            end
            line_mem[oldest_line][c] = px;
            window_val = column_val;
            for (int k = 0; k < LINES; k++)
            begin
                window_val = reduce_pair(window_val, column_hist[k]);
            end
            for (int k = LINES - 1; k > 0; k--)
            begin
                column_hist[k] = column_hist[k-1];
            end
            column_hist[0] = column_val;
            if (r >= LINES && c >= LINES)
            begin
                res.value = window_val;
                res.row   = POS_W'(r - LINES + HALF);
                res.col   = POS_W'(c - LINES + HALF);
                res.done  = (r + 1 == h) && (c + 1 == w);
                pending_results.insert(pending_results.size(), res);
            end
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                oldest_line = (oldest_line + 1) % LINES;
                if (r >= h)
                begin
                    r = 0;
                    oldest_line = 0;
                end
            end
            next_col = c;
            next_row = r;
        end
    endtask

    always @(posedge clk)
    begin
        window_result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("unexpected result: value %0d row %0d col %0d done %0b",
                             result_bus.filtered_value, result_bus.center_row,
                             result_bus.center_column, result_bus.frame_done);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_bus.filtered_value !== want.value
                    || result_bus.center_row !== want.row
                    || result_bus.center_column !== want.col
                    || result_bus.frame_done !== want.done)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("mismatch: expected value %0d row %0d col %0d done %0b",
                                 want.value, want.row, want.col, want.done);
                        $display("          got      value %0d row %0d col %0d done %0b",
                                 result_bus.filtered_value, result_bus.center_row,
                                 result_bus.center_column, result_bus.frame_done);
                    end
                end
            end
        end
    end

    // one pixel request; valid stays high when the next one follows at once
    task automatic send_pixel(input pixel_t px);
        begin
            while ($urandom_range(99) < tx_idle_pct)
            begin
                pixel_bus.valid <= 1'b0;
                @(posedge clk);
            end
            pixel_bus.valid       <= 1'b1;
            pixel_bus.pixel_value <= px;
            do
            begin
                @(posedge clk);
            end
            while (!pixel_bus.ready);
            predict_pixel(px);
            pixels_sent++;
        end
    endtask

    // drain all results, then let the pipeline empty out
    task automatic settle_filter();
        begin
            pixel_bus.valid <= 1'b0;
            while (pending_results.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic apb_write(input int unsigned idx, input logic [DATA_W-1:0] value);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_W'(idx * 4);
            pwdata  <= value;
            @(posedge clk);
            penable <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!pready);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            apply_register(idx, value);
        end
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h, input mode_t m);
        begin
            settle_filter();
            apb_write(REG_WIDTH,
                      (($urandom_range(1) ? $urandom : 32'h0) << CFG_W) | DATA_W'(w));
            apb_write(REG_HEIGHT,
                      (($urandom_range(1) ? $urandom : 32'h0) << CFG_W) | DATA_W'(h));
            apb_write(REG_MODE,
                      (($urandom_range(1) ? $urandom : 32'h0) << 1) | DATA_W'(m));
            frames_set++;
        end
    endtask

    function automatic pixel_t make_pixel(input pixel_style_t style, input pixel_t base);
        case (style)
            PIX_EXTREME:
                return $urandom_range(1) ? ($urandom_range(1) ? 8'hFF : 8'hFE)
                                         : ($urandom_range(1) ? 8'h00 : 8'h01);
            PIX_BAND:
                return base ^ pixel_t'($urandom_range(7));
            default:
                return pixel_t'($urandom);
        endcase
    endfunction

    // two 5x5 frames back to back: corner minimum, then corner maximum
    task automatic test_directed_frames();
        begin
            settle_filter();
            apb_write(REG_WIDTH, 32'hFFFF_F005);
            apb_write(REG_HEIGHT, 32'd5);
            apb_write(REG_MODE, MODE_MIN);
            apb_write(REG_UNMAPPED, 32'hFFFF_FFFF);
            for (int i = 0; i < 25; i++)
            begin
                send_pixel((i == 0) ? 8'h00 : pixel_t'(8'hFF - i));
            end
            settle_filter();
            apb_write(REG_MODE, 32'hFFFF_FFFF);
            apb_write(REG_UNMAPPED, 32'h0);
            for (int i = 0; i < 25; i++)
            begin
                send_pixel((i == 24) ? 8'hFF : pixel_t'(i + 1));
            end
        end
    endtask

    // frames smaller than the window never produce a result
    task automatic test_tiny_frames();
        begin
            set_frame(0, 0, MODE_MAX);
            repeat (6) send_pixel(pixel_t'($urandom));
            set_frame(4, 4, MODE_MIN);
            repeat (20) send_pixel(pixel_t'($urandom));
            set_frame(5, 4, MODE_MAX);
            repeat (20) send_pixel(pixel_t'($urandom));
            set_frame(4, 9, MODE_MIN);
            repeat (40) send_pixel(pixel_t'($urandom));
        end
    endtask

    task automatic test_random_frames(input int unsigned target, input int unsigned tx_pct,
                                      input int unsigned rx_pct);
        int unsigned  sent;
        int unsigned  w;
        int unsigned  h;
        int unsigned  frame_len;
        int unsigned  count;
        int unsigned  switch_at;
        int unsigned  pick;
        pixel_style_t style;
        pixel_t       base;
        begin
            tx_idle_pct = tx_pct;
            rx_idle_pct = rx_pct;
            sent = 0;
            while (sent < target)
            begin
                pick = $urandom_range(99);
                w = (pick < 70) ? $urandom_range(5, 12) :
                    (pick < 85) ? $urandom_range(13, 40) :
                    (pick < 93) ? $urandom_range(0, 4) : $urandom_range(41, 64);
                h = ($urandom_range(9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 9);
                set_frame(w, h, mode_t'($urandom_range(1)));
                frame_len = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
                pick = $urandom_range(9);
                // mostly whole frames; some run into the next frame, some stop short
                count = (pick == 0) ? frame_len + $urandom_range(1, frame_len) :
                        (pick == 1) ? $urandom_range(1, frame_len) : frame_len;
                switch_at = ($urandom_range(4) == 0) ? $urandom_range(1, count) : count + 1;
                style = pixel_style_t'($urandom_range(2));
                base  = pixel_t'($urandom);
                for (int i = 0; i < count; i++)
                begin
                    if (i == switch_at)
                    begin
                        settle_filter();
                        apb_write(REG_MODE, (mode_reg == MODE_MAX) ? MODE_MIN : MODE_MAX);
                        mode_switches++;
                    end
                    send_pixel(make_pixel(style, base));
                end
                sent += count;
            end
        end
    endtask

    // saturated width and height settings, each with the start of a frame
    task automatic test_size_extremes();
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
            set_frame(12'hFFF, 5, MODE_MAX);
            repeat (EXTREME_PIXELS) send_pixel(pixel_t'($urandom));
            set_frame(5, 12'hFFF, MODE_MIN);
            repeat (EXTREME_PIXELS) send_pixel(pixel_t'($urandom));
        end
    endtask

    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        pixel_bus.valid       = 1'b0;
        pixel_bus.pixel_value = '0;
        result_bus.ready      = 1'b0;
        cycle_count           = 0;
        mismatches            = 0;
        pixels_sent           = 0;
        results_checked       = 0;
        frames_set            = 0;
        mode_switches         = 0;
        tx_idle_pct           = 34;
        rx_idle_pct           = 85;
        width_reg             = 12'd640;
        height_reg            = 12'd480;
        mode_reg              = MODE_MIN;
        next_row              = 0;
        next_col              = 0;
        oldest_line           = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_tiny_frames();
        test_random_frames(420, 34, 85);
        test_random_frames(420, 85, 34);
        test_random_frames(420, 0, 0);
        test_size_extremes();
        settle_filter();

        $display("covered %0d pixels, %0d results checked, %0d frame setups, %0d mode switches",
                 pixels_sent, results_checked, frames_set, mode_switches);
        $display("size settings from zero up to saturated width and height, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
        begin
            $display("separable_window_min_max_filter_unit regression: pass");
        end
        else
        begin
            $display("separable_window_min_max_filter_unit regression: fail");
        end
        $finish;
    end

endmodule

// File: separable_window_min_max_filter_unit.f
+incdir+rtl
rtl/swmm_pkg.sv
rtl/swmm_pix_if.sv
rtl/swmm_res_if.sv
rtl/swmm_ram.sv
rtl/swmm_cfg.sv
rtl/swmm_scan.sv
rtl/swmm_reduce.sv
rtl/separable_window_min_max_filter_unit.sv
dv/tb_top.sv
